// ===== hw/rtl/gauss_jordan_pivot_solver_core_defines.svh =====
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef GAUSS_JORDAN_PIVOT_SOLVER_CORE_DEFINES_SVH
`define GAUSS_JORDAN_PIVOT_SOLVER_CORE_DEFINES_SVH

`define GJPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gjps same-cycle check failed");

`define GJPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gjps next-cycle check failed");

`endif

// ===== hw/rtl/gjps_pkg.sv =====
package gjps_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam logic [6:0] ORDER_RESET = 7'd16;
  localparam logic [12:0] COUNT_MAX = 13'd8191;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic signed [31:0] element;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [5:0]         row;
    logic signed [31:0] diagonal;
    logic signed [31:0] rhs;
    logic [1:0]         status;
    logic               final_res;
  } out_t;

  typedef struct packed {
    logic               go;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
    logic               sat;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT,
    S_P_RD0, S_P_C0, S_P_RD, S_P_CMP, S_SWAP, S_V_RD, S_V_GET,
    S_E_RD, S_E_GET, S_E_DIV, S_E_RK, S_E_MUL, S_E_UPD, S_E_CLR, S_F_NEXT,
    S_B_RD, S_B_GET, S_B_GET2, S_BE_RD, S_BE_GET, S_BE_DIV, S_BE_MUL,
    S_BE_UPD, S_BE_CLR,
    S_O_RD, S_O_RD2, S_O_EMIT
  } state_t;

endpackage

// ===== hw/rtl/gjps_ram.sv =====
module gjps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 272
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gjps_div.sv =====
module gjps_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gjps_pkg::div_req_t  req,
  output gjps_pkg::div_rsp_t  rsp
);

  // restoring divide of |num|<<16 by |den|, one quotient bit a cycle
  logic [47:0] nm_r;
  logic [31:0] dm_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        neg_r;
  logic        done_r;

  logic [32:0] rem_w;
  logic        ge_w;
  logic [31:0] na_w;
  logic [31:0] da_w;

  assign rem_w = {rem_r, nm_r[47]};
  assign ge_w  = rem_w >= {1'b0, dm_r};
  assign na_w  = req.num[31] ? 32'(-req.num) : req.num;
  assign da_w  = req.den[31] ? 32'(-req.den) : req.den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= 6'd48;
        nm_r  <= {na_w, 16'd0};
        dm_r  <= da_w;
        rem_r <= '0;
        neg_r <= req.num[31] ^ req.den[31];
      end else if (run_r) begin
        rem_r <= ge_w ? 32'(rem_w - {1'b0, dm_r}) : rem_w[31:0];
        nm_r  <= {nm_r[46:0], ge_w};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  logic sat_w;
  always_comb begin
    sat_w = neg_r ? (nm_r > 48'h0000_8000_0000) : (nm_r > 48'h0000_7FFF_FFFF);
    rsp.done = done_r;
    rsp.sat  = sat_w;
    if (sat_w) begin
      rsp.quo = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rsp.quo = neg_r ? 32'(-nm_r[31:0]) : nm_r[31:0];
    end
  end

endmodule

// ===== hw/rtl/gauss_jordan_pivot_solver_core.sv =====
// loading: elements are written to the store while idle; after the last element the
// solve steps through the store, one ram access or multiply per step, and uses the
// shared bit-serial divider once per eliminated row
// throughput: one element per cycle between solves; busy stays high during a solve
// results: n strobes in order of row index at the end of the solve, receiver cannot stall
// reset: synchronous active-low rst_n; order returns to 16, permutation to identity
`include "gauss_jordan_pivot_solver_core_defines.svh"

module gauss_jordan_pivot_solver_core #(
  parameter int MAX_ORDER = gjps_pkg::MAX_ORDER_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  gjps_pkg::in_t   in_data,
  output logic            out_valid,
  output gjps_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [6:0]      cfg_data
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ORDER);
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int PW    = RW + CW + 2;

  gjps_pkg::state_t state_r, state_nxt;

  logic [6:0]         order_r;
  logic [12:0]        load_cnt_r;
  logic [CW-1:0]      n_r, k_r, i_r, j_r, best_r;
  logic [RW-1:0]      rord_r [MAX_ORDER];
  logic [31:0]        bmag_r;
  logic signed [31:0] piv_r, f_r, bkn_r, diag_r;
  logic signed [63:0] prod_r;
  logic [1:0]         err_r;

  logic [31:0]        rdata;
  logic signed [31:0] rd_s;
  logic [AW-1:0]      addr;
  logic               we;
  logic [31:0]        wdata;
  logic [CW-1:0]      rowsel, colsel;
  logic [PW-1:0]      cell_w;
  logic               accept;

  gjps_pkg::div_req_t dreq;
  gjps_pkg::div_rsp_t drsp;

  assign rd_s      = $signed(rdata);
  assign busy      = state_r != gjps_pkg::S_IDLE;
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  gjps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(addr), .wdata(wdata), .raddr(addr), .rdata_r(rdata)
  );

  gjps_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // clamped order
  logic [CW-1:0] n_w;
  always_comb begin
    if (order_r == 7'd0) begin
      n_w = CW'(1);
    end else if (order_r > 7'(MAX_ORDER)) begin
      n_w = CW'(MAX_ORDER);
    end else begin
      n_w = CW'(order_r);
    end
  end

  // update arithmetic: a - floor(prod / 2^16), saturated
  logic signed [47:0] qm_w;
  logic signed [49:0] diff_w;
  logic               sat_hi, sat_lo;
  logic [31:0]        upd_w;
  logic signed [31:0] mul_a;
  logic signed [63:0] prod_w;

  assign qm_w   = prod_r[63:16];
  assign diff_w = 50'(rd_s) - 50'(qm_w);
  assign sat_hi = !diff_w[49] && (|diff_w[48:31]);
  assign sat_lo = diff_w[49] && !(&diff_w[48:31]);
  assign upd_w  = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : diff_w[31:0]);
  assign mul_a  = (state_r == gjps_pkg::S_E_MUL) ? rd_s : bkn_r;
  assign prod_w = mul_a * f_r;

  assign cell_w = PW'(rord_r[rowsel[RW-1:0]]) * PW'(n_r + CW'(1)) + PW'(colsel);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gjps_pkg::S_IDLE:  if (accept && in_data.last) state_nxt = gjps_pkg::S_INIT;
      gjps_pkg::S_INIT:  state_nxt = gjps_pkg::S_P_RD0;
      gjps_pkg::S_P_RD0: state_nxt = gjps_pkg::S_P_C0;
      gjps_pkg::S_P_C0:
        state_nxt = (k_r + CW'(1) < n_r) ? gjps_pkg::S_P_RD : gjps_pkg::S_SWAP;
      gjps_pkg::S_P_RD:  state_nxt = gjps_pkg::S_P_CMP;
      gjps_pkg::S_P_CMP:
        state_nxt = (i_r + CW'(1) < n_r) ? gjps_pkg::S_P_RD : gjps_pkg::S_SWAP;
      gjps_pkg::S_SWAP:  state_nxt = gjps_pkg::S_V_RD;
      gjps_pkg::S_V_RD:  state_nxt = gjps_pkg::S_V_GET;
      gjps_pkg::S_V_GET:
        state_nxt = (k_r + CW'(1) < n_r) ? gjps_pkg::S_E_RD : gjps_pkg::S_F_NEXT;
      gjps_pkg::S_E_RD:  state_nxt = gjps_pkg::S_E_GET;
      gjps_pkg::S_E_GET:
        state_nxt = (piv_r != 0) ? gjps_pkg::S_E_DIV : gjps_pkg::S_E_CLR;
      gjps_pkg::S_E_DIV: if (drsp.done) state_nxt = gjps_pkg::S_E_RK;
      gjps_pkg::S_E_RK:  state_nxt = gjps_pkg::S_E_MUL;
      gjps_pkg::S_E_MUL: state_nxt = gjps_pkg::S_E_UPD;
      gjps_pkg::S_E_UPD:
        state_nxt = (j_r < n_r) ? gjps_pkg::S_E_RK : gjps_pkg::S_E_CLR;
      gjps_pkg::S_E_CLR:
        state_nxt = (i_r + CW'(1) < n_r) ? gjps_pkg::S_E_RD : gjps_pkg::S_F_NEXT;
      gjps_pkg::S_F_NEXT: begin
        if (k_r + CW'(1) < n_r) state_nxt = gjps_pkg::S_P_RD0;
        else if (n_r > CW'(1)) state_nxt = gjps_pkg::S_B_RD;
        else state_nxt = gjps_pkg::S_O_RD;
      end
      gjps_pkg::S_B_RD:   state_nxt = gjps_pkg::S_B_GET;
      gjps_pkg::S_B_GET:  state_nxt = gjps_pkg::S_B_GET2;
      gjps_pkg::S_B_GET2: state_nxt = gjps_pkg::S_BE_RD;
      gjps_pkg::S_BE_RD:  state_nxt = gjps_pkg::S_BE_GET;
      gjps_pkg::S_BE_GET:
        state_nxt = (piv_r != 0) ? gjps_pkg::S_BE_DIV : gjps_pkg::S_BE_CLR;
      gjps_pkg::S_BE_DIV: if (drsp.done) state_nxt = gjps_pkg::S_BE_MUL;
      gjps_pkg::S_BE_MUL: state_nxt = gjps_pkg::S_BE_UPD;
      gjps_pkg::S_BE_UPD: state_nxt = gjps_pkg::S_BE_CLR;
      gjps_pkg::S_BE_CLR: begin
        if (i_r != '0) state_nxt = gjps_pkg::S_BE_RD;
        else if (k_r == CW'(1)) state_nxt = gjps_pkg::S_O_RD;
        else state_nxt = gjps_pkg::S_B_RD;
      end
      gjps_pkg::S_O_RD:  state_nxt = gjps_pkg::S_O_RD2;
      gjps_pkg::S_O_RD2: state_nxt = gjps_pkg::S_O_EMIT;
      gjps_pkg::S_O_EMIT:
        state_nxt = (i_r + CW'(1) < n_r) ? gjps_pkg::S_O_RD : gjps_pkg::S_IDLE;
      default: state_nxt = gjps_pkg::S_IDLE;
    endcase
  end

  // outputs: store port, divider request, result strobe
  always_comb begin
    rowsel    = k_r;
    colsel    = k_r;
    we        = 1'b0;
    wdata     = '0;
    out_valid = 1'b0;
    dreq.go   = 1'b0;
    dreq.num  = rd_s;
    dreq.den  = piv_r;
    case (state_r)
      gjps_pkg::S_P_RD, gjps_pkg::S_E_RD, gjps_pkg::S_BE_RD: rowsel = i_r;
      gjps_pkg::S_E_RK:  colsel = j_r;
      gjps_pkg::S_E_MUL: begin
        rowsel = i_r;
        colsel = j_r;
      end
      gjps_pkg::S_E_UPD: begin
        rowsel = i_r;
        colsel = j_r;
        we     = 1'b1;
        wdata  = upd_w;
      end
      gjps_pkg::S_E_CLR, gjps_pkg::S_BE_CLR: begin
        rowsel = i_r;
        we     = 1'b1;
      end
      gjps_pkg::S_E_GET, gjps_pkg::S_BE_GET: dreq.go = piv_r != 0;
      gjps_pkg::S_B_GET: colsel = n_r;
      gjps_pkg::S_BE_MUL: begin
        rowsel = i_r;
        colsel = n_r;
      end
      gjps_pkg::S_BE_UPD: begin
        rowsel = i_r;
        colsel = n_r;
        we     = 1'b1;
        wdata  = upd_w;
      end
      gjps_pkg::S_O_RD: begin
        rowsel = i_r;
        colsel = i_r;
      end
      gjps_pkg::S_O_RD2: begin
        rowsel = i_r;
        colsel = n_r;
      end
      gjps_pkg::S_O_EMIT: out_valid = 1'b1;
      default: ;
    endcase
    addr = cell_w[AW-1:0];
    if (state_r == gjps_pkg::S_IDLE) begin
      addr  = AW'(load_cnt_r);
      we    = accept && (load_cnt_r < 13'(DEPTH));
      wdata = in_data.element;
    end
  end

  always_comb begin
    out_data.row       = 6'(i_r);
    out_data.diagonal  = diag_r;
    out_data.rhs       = rd_s;
    out_data.status    = err_r[0] ? gjps_pkg::ST_ZERO
                       : (err_r[1] ? gjps_pkg::ST_SAT : gjps_pkg::ST_OK);
    out_data.final_res = (i_r + CW'(1)) == n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gjps_pkg::S_IDLE;
      order_r    <= gjps_pkg::ORDER_RESET;
      load_cnt_r <= '0;
      err_r      <= '0;
      for (int x = 0; x < MAX_ORDER; x++) begin
        rord_r[x] <= RW'(x);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_data;
      end
      case (state_r)
        gjps_pkg::S_IDLE: begin
          if (accept) begin
            if (load_cnt_r != gjps_pkg::COUNT_MAX) load_cnt_r <= load_cnt_r + 13'd1;
            if (in_data.last) n_r <= n_w;
          end
        end
        gjps_pkg::S_INIT: begin
          for (int x = 0; x < MAX_ORDER; x++) begin
            rord_r[x] <= RW'(x);
          end
          err_r <= '0;
          k_r   <= '0;
        end
        gjps_pkg::S_P_C0: begin
          best_r <= k_r;
          bmag_r <= rd_s[31] ? 32'(-rd_s) : rdata;
          i_r    <= k_r + CW'(1);
        end
        gjps_pkg::S_P_CMP: begin
          // strict compare keeps the first row of largest magnitude
          if ((rd_s[31] ? 32'(-rd_s) : rdata) > bmag_r) begin
            best_r <= i_r;
            bmag_r <= rd_s[31] ? 32'(-rd_s) : rdata;
          end
          i_r <= i_r + CW'(1);
        end
        gjps_pkg::S_SWAP: begin
          rord_r[k_r[RW-1:0]]    <= rord_r[best_r[RW-1:0]];
          rord_r[best_r[RW-1:0]] <= rord_r[k_r[RW-1:0]];
        end
        gjps_pkg::S_V_GET: begin
          piv_r <= rd_s;
          if (rd_s == 0) err_r[0] <= 1'b1;
          i_r <= k_r + CW'(1);
        end
        gjps_pkg::S_E_DIV, gjps_pkg::S_BE_DIV: begin
          if (drsp.done) begin
            f_r <= drsp.quo;
            if (drsp.sat) err_r[1] <= 1'b1;
            j_r <= k_r + CW'(1);
          end
        end
        gjps_pkg::S_E_MUL, gjps_pkg::S_BE_MUL: prod_r <= prod_w;
        gjps_pkg::S_E_UPD: begin
          if (sat_hi || sat_lo) err_r[1] <= 1'b1;
          j_r <= j_r + CW'(1);
        end
        gjps_pkg::S_BE_UPD: if (sat_hi || sat_lo) err_r[1] <= 1'b1;
        gjps_pkg::S_E_CLR: i_r <= i_r + CW'(1);
        gjps_pkg::S_F_NEXT: begin
          k_r <= (k_r + CW'(1) < n_r) ? k_r + CW'(1) : n_r - CW'(1);
          i_r <= '0;
        end
        gjps_pkg::S_B_GET:  piv_r <= rd_s;
        gjps_pkg::S_B_GET2: begin
          bkn_r <= rd_s;
          i_r   <= k_r - CW'(1);
        end
        gjps_pkg::S_BE_CLR: begin
          if (i_r != '0) begin
            i_r <= i_r - CW'(1);
          end else begin
            k_r <= k_r - CW'(1);
          end
        end
        gjps_pkg::S_O_RD2: diag_r <= rd_s;
        gjps_pkg::S_O_EMIT: begin
          i_r <= i_r + CW'(1);
          if (state_nxt == gjps_pkg::S_IDLE) load_cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  `GJPS_ASSERT_SAME(a_out_in_solve, out_valid, busy && !cfg_ready)
  `GJPS_ASSERT_NEXT(a_last_starts, accept && in_data.last, busy)
  `GJPS_ASSERT_NEXT(a_final_ends, out_valid && out_data.final_res, !busy && load_cnt_r == '0)

endmodule
